@@ rtl/oqsud_pkg.sv @@
// ----------------------------------------------------------------------------
// oqsud_pkg
// Shared constants, codes and types of the ordered queue with search, update
// and delete.
// ----------------------------------------------------------------------------
package oqsud_pkg;

  // Queue geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_SEARCH = 3'd1,
    OP_MODIFY = 3'd2,
    OP_DELETE = 3'd3,
    OP_DUMP   = 3'd4
  } opcode_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP,
    S_RESP
  } state_e;

  // One write port and one read port of the entry store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // One result transaction
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] entry_value;
    logic              last_item;
  } result_t;

endpackage

@@ rtl/oqsud_if.sv @@
// ----------------------------------------------------------------------------
// oqsud_if
// Valid/ready channels of the queue: the command channel and the result
// channel.
// ----------------------------------------------------------------------------
interface oqsud_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [oqsud_pkg::OP_W-1:0]            opcode;
  logic signed [oqsud_pkg::DATA_W-1:0]   key_value;
  logic signed [oqsud_pkg::DATA_W-1:0]   new_value;

  modport source (output valid, output opcode, output key_value, output new_value,
                  input ready);
  modport sink   (input valid, input opcode, input key_value, input new_value,
                  output ready);
endinterface

interface oqsud_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [oqsud_pkg::STAT_W-1:0]          status;
  logic signed [oqsud_pkg::DATA_W-1:0]   entry_value;
  logic                                  last_item;

  modport source (output valid, output status, output entry_value, output last_item,
                  input ready);
  modport sink   (input valid, input status, input entry_value, input last_item,
                  output ready);
endinterface

@@ rtl/oqsud_store.sv @@
// ----------------------------------------------------------------------------
// oqsud_store
// Entry store: DEPTH words, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module oqsud_store (
  input  logic                            clk_i,
  input  oqsud_pkg::mem_req_t             req_i,
  output logic [oqsud_pkg::DATA_W-1:0]    rdata_o
);

  logic [oqsud_pkg::DATA_W-1:0] mem [oqsud_pkg::DEPTH];
  logic [oqsud_pkg::DATA_W-1:0] rdata_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/oqsud_ctrl.sv @@
// ----------------------------------------------------------------------------
// oqsud_ctrl
// Command sequencer: appends at the tail and walks the entry store one word
// per cycle to search, modify, delete with shift, and dump (held on stall).
// ----------------------------------------------------------------------------
module oqsud_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  logic [oqsud_pkg::OP_W-1:0]       cmd_opcode_i,
  input  logic [oqsud_pkg::DATA_W-1:0]     cmd_key_i,
  input  logic [oqsud_pkg::DATA_W-1:0]     cmd_new_i,
  output oqsud_pkg::mem_req_t              mem_req_o,
  input  logic [oqsud_pkg::DATA_W-1:0]     mem_rdata_i,
  output logic                             res_valid_o,
  output oqsud_pkg::result_t               res_o,
  input  logic                             res_ready_i
);

  oqsud_pkg::state_e                state_q, state_d;
  oqsud_pkg::opcode_e               op_q, op_d;
  oqsud_pkg::status_e               status_q, status_d;
  logic [oqsud_pkg::DATA_W-1:0]     key_q, key_d;
  logic [oqsud_pkg::DATA_W-1:0]     nv_q, nv_d;
  logic [oqsud_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [oqsud_pkg::CNT_W-1:0]      count_q, count_d;

  logic [oqsud_pkg::IDX_W-1:0]      idx_next;
  logic [oqsud_pkg::CNT_W-1:0]      idx_inc;
  logic                             at_last;

  assign idx_next = idx_q + oqsud_pkg::IDX_W'(1);
  assign idx_inc  = oqsud_pkg::CNT_W'(idx_q) + oqsud_pkg::CNT_W'(1);
  assign at_last  = (idx_inc >= count_q);

  // Hold state and count; payload registers need no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oqsud_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    key_q    <= key_d;
    nv_q     <= nv_d;
    idx_q    <= idx_d;
  end

  // Sequence each command
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    key_d       = key_q;
    nv_d        = nv_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cmd_ready_o = 1'b0;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '{status: status_q, entry_value: key_q, last_item: 1'b1};

    unique case (state_q)
      oqsud_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d  = oqsud_pkg::opcode_e'(cmd_opcode_i);
          key_d = cmd_key_i;
          nv_d  = cmd_new_i;
          idx_d = '0;
          unique case (cmd_opcode_i) inside
            oqsud_pkg::OP_APPEND: begin
              if (count_q >= oqsud_pkg::CNT_W'(oqsud_pkg::DEPTH)) begin
                status_d = oqsud_pkg::ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = count_q[oqsud_pkg::IDX_W-1:0];
                mem_req_o.wdata = cmd_key_i;
                count_d         = count_q + oqsud_pkg::CNT_W'(1);
                status_d        = oqsud_pkg::ST_DONE;
              end
              state_d = oqsud_pkg::S_RESP;
            end
            oqsud_pkg::OP_SEARCH, oqsud_pkg::OP_MODIFY, oqsud_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                status_d = oqsud_pkg::ST_EMPTY;
                state_d  = oqsud_pkg::S_RESP;
              end else begin
                state_d  = oqsud_pkg::S_SCAN;
              end
            end
            oqsud_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                status_d = oqsud_pkg::ST_EMPTY;
                key_d    = '0;
                state_d  = oqsud_pkg::S_RESP;
              end else begin
                state_d  = oqsud_pkg::S_DUMP;
              end
            end
            default: ;  // undefined opcodes: drop silently
          endcase
        end
      end

      // Compare one entry per cycle, prefetch the next
      oqsud_pkg::S_SCAN: begin
        mem_req_o.raddr = idx_next;
        if (mem_rdata_i == key_q) begin
          status_d = oqsud_pkg::ST_DONE;
          if (op_q == oqsud_pkg::OP_MODIFY) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_q;
            mem_req_o.wdata = nv_q;
          end
          state_d = (op_q == oqsud_pkg::OP_DELETE) ? oqsud_pkg::S_SHIFT
                                                  : oqsud_pkg::S_RESP;
        end else if (at_last) begin
          status_d = oqsud_pkg::ST_NOT_FOUND;
          state_d  = oqsud_pkg::S_RESP;
        end else begin
          idx_d = idx_next;
        end
      end

      // Move each later entry down by one, then drop the tail
      oqsud_pkg::S_SHIFT: begin
        mem_req_o.raddr = idx_q + oqsud_pkg::IDX_W'(2);
        if (at_last) begin
          count_d = count_q - oqsud_pkg::CNT_W'(1);
          state_d = oqsud_pkg::S_RESP;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = idx_q;
          mem_req_o.wdata = mem_rdata_i;
          idx_d           = idx_next;
        end
      end

      // Emit one entry per accepted transaction, reread on stall
      oqsud_pkg::S_DUMP: begin
        res_valid_o = 1'b1;
        res_o       = '{status: oqsud_pkg::ST_DONE, entry_value: mem_rdata_i,
                        last_item: at_last};
        mem_req_o.raddr = res_ready_i ? idx_next : idx_q;
        if (res_ready_i) begin
          if (at_last) begin
            state_d = oqsud_pkg::S_IDLE;
          end else begin
            idx_d = idx_next;
          end
        end
      end

      oqsud_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = oqsud_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = oqsud_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/oqsud_out.sv @@
// ----------------------------------------------------------------------------
// oqsud_out
// Output register: holds one result transaction so the sequencer can move on
// while the receiver stalls.
// ----------------------------------------------------------------------------
module oqsud_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  oqsud_pkg::result_t   res_i,
  output logic                 res_ready_o,
  oqsud_rsp_if.source          rsp_o
);

  logic               valid_q;
  oqsud_pkg::result_t data_q;

  assign res_ready_o = !valid_q || rsp_o.ready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  // Load payload when the slot frees
  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.status      = data_q.status;
  assign rsp_o.entry_value = data_q.entry_value;
  assign rsp_o.last_item   = data_q.last_item;

endmodule

@@ rtl/ordered_queue_search_update_delete.sv @@
// ----------------------------------------------------------------------------
// ordered_queue_search_update_delete
// Ordered queue of up to DEPTH signed 32-bit values with search, modify,
// delete and dump.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command per transaction (opcode, key_value, new_value).
//   rsp_o returns results (status, entry_value, last_item); every command
//   except an undefined opcode gives one result, a dump of a non-empty queue
//   one per entry with last_item on the final one.
// Operation:
//   Search, modify and delete read one entry per cycle from the single read
//   port of the entry store; a delete that finds its key then shifts each
//   later entry down, one entry per cycle. A dump sends one entry per cycle
//   while the output register accepts and waits while it is stalled.
//   One command is worked on at a time; the next is taken in the cycle after
//   the last result has moved into the output register.
// Reset clears the entry count and the control state; the store keeps its
// contents, whose words beyond the count are never used.
// A stalled receiver holds the output register; the sequencer waits behind it
// and a dump resumes at the stalled entry.
// ----------------------------------------------------------------------------
module ordered_queue_search_update_delete (
  input  logic          clk_i,
  input  logic          rst_ni,
  oqsud_cmd_if.sink     cmd_i,
  oqsud_rsp_if.source   rsp_o
);

  oqsud_pkg::mem_req_t             mem_req;
  logic [oqsud_pkg::DATA_W-1:0]    mem_rdata;
  logic                            res_valid;
  logic                            res_ready;
  oqsud_pkg::result_t              res;

  oqsud_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_i.valid),
    .cmd_ready_o  (cmd_i.ready),
    .cmd_opcode_i (cmd_i.opcode),
    .cmd_key_i    (cmd_i.key_value),
    .cmd_new_i    (cmd_i.new_value),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  oqsud_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  oqsud_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .rsp_o       (rsp_o)
  );

endmodule

@@ tb/ordered_queue_search_update_delete_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_queue_search_update_delete_tb
// Self-checking bench for the ordered queue. A driver offers commands from a
// backlog built at time zero. A behavioral queue predicts every result at
// command acceptance, and each result leaving the block is compared field by
// field against the oldest prediction. Both channels idle in random bursts,
// the result side holds off once for a long stretch, and the sender pauses
// twice until all results have drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_queue_search_update_delete_tb;

  // Opcodes outside the defined set, which the block ignores
  localparam logic [oqsud_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [oqsud_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam logic [oqsud_pkg::DATA_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [oqsud_pkg::DATA_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [oqsud_pkg::DATA_W-1:0] KEY_NEG = 32'hffff_ffff;

  localparam int RAND_ITEMS   = 62;
  localparam int CALM_ITEMS   = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {
    K_CMD,
    K_HOLD,
    K_DRAIN
  } slot_kind_e;

  typedef struct {
    slot_kind_e                   kind;
    logic [oqsud_pkg::OP_W-1:0]   opcode;
    logic [oqsud_pkg::DATA_W-1:0] key;
    logic [oqsud_pkg::DATA_W-1:0] nv;
    bit                           may_idle;
  } cmd_slot_t;

  logic clk;
  logic rst_n;

  oqsud_cmd_if cmd_if ();
  oqsud_rsp_if rsp_if ();

  ordered_queue_search_update_delete u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // Stimulus backlog, predicted queue contents and pending results
  cmd_slot_t                    backlog[$];
  logic [oqsud_pkg::DATA_W-1:0] held_vals[$];
  oqsud_pkg::result_t           due_results[$];
  logic [oqsud_pkg::DATA_W-1:0] key_pool[8];

  int  cmds_total;
  int  cmds_left;
  int  cmds_taken;
  int  gap_left;
  int  hold_req;
  int  hold_ack;
  int  hold_left;
  int  stall_left;
  int  cycles;
  int  errors;
  int  results_seen;
  int  ignored_cmds;
  int  op_seen[8];
  int  status_seen[4];
  bit  cmd_fire;
  bit  rsp_fire;
  bit  idle_ok;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the predicted queue and queue up its results
  function automatic void apply_command(logic [oqsud_pkg::OP_W-1:0] op,
                                        logic [oqsud_pkg::DATA_W-1:0] key,
                                        logic [oqsud_pkg::DATA_W-1:0] nv);
    int                 hit;
    oqsud_pkg::result_t r;
    hit = -1;
    for (int i = 0; i < held_vals.size(); i++) begin
      if (hit < 0 && held_vals[i] == key) hit = i;
    end
    r.status      = oqsud_pkg::ST_DONE;
    r.entry_value = key;
    r.last_item   = 1'b1;
    case (op)
      oqsud_pkg::OP_APPEND: begin
        if (held_vals.size() >= oqsud_pkg::DEPTH) r.status = oqsud_pkg::ST_FULL;
        else held_vals.push_back(key);
        due_results.push_back(r);
      end
      oqsud_pkg::OP_SEARCH, oqsud_pkg::OP_MODIFY, oqsud_pkg::OP_DELETE: begin
        if (held_vals.size() == 0) r.status = oqsud_pkg::ST_EMPTY;
        else if (hit < 0) r.status = oqsud_pkg::ST_NOT_FOUND;
        else if (op == oqsud_pkg::OP_MODIFY) held_vals[hit] = nv;
        else if (op == oqsud_pkg::OP_DELETE) held_vals.delete(hit);
        due_results.push_back(r);
      end
      oqsud_pkg::OP_DUMP: begin
        if (held_vals.size() == 0) begin
          r.status      = oqsud_pkg::ST_EMPTY;
          r.entry_value = '0;
          due_results.push_back(r);
        end else begin
          foreach (held_vals[i]) begin
            r.entry_value = held_vals[i];
            r.last_item   = (i == held_vals.size() - 1);
            due_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_field(string fname, logic [oqsud_pkg::DATA_W-1:0] exp_v,
                                       logic [oqsud_pkg::DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, act_v);
    end
  endfunction

  function automatic void queue_cmd(logic [oqsud_pkg::OP_W-1:0] op,
                                    logic [oqsud_pkg::DATA_W-1:0] key,
                                    logic [oqsud_pkg::DATA_W-1:0] nv, bit may_idle);
    cmd_slot_t s;
    s.kind     = K_CMD;
    s.opcode   = op;
    s.key      = key;
    s.nv       = nv;
    s.may_idle = may_idle;
    backlog.push_back(s);
    cmds_total++;
    cmds_left++;
  endfunction

  function automatic void queue_marker(slot_kind_e kind);
    cmd_slot_t s;
    s.kind     = kind;
    s.opcode   = oqsud_pkg::OP_APPEND;
    s.key      = '0;
    s.nv       = '0;
    s.may_idle = 1'b0;
    backlog.push_back(s);
  endfunction

  // Keys partly from a small pool so that matches and duplicates are common
  function automatic logic [oqsud_pkg::DATA_W-1:0] pick_key(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Driver: offer the next backlog entry once the current one is taken
  always @(negedge clk) begin : cmd_driver
    cmd_slot_t nxt;
    bit        send;
    if (rst_n && (!cmd_if.valid || cmd_fire)) begin
      send = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (backlog.size() > 0) begin
        case (backlog[0].kind)
          K_HOLD: begin
            hold_req <= hold_req + 1;
            void'(backlog.pop_front());
          end
          K_DRAIN: begin
            if (due_results.size() == 0) void'(backlog.pop_front());
          end
          default: begin
            nxt  = backlog.pop_front();
            send = 1'b1;
            cmds_left--;
            cmd_if.opcode    <= nxt.opcode;
            cmd_if.key_value <= nxt.key;
            cmd_if.new_value <= nxt.nv;
            idle_ok          <= nxt.may_idle && (cmds_left > CALM_ITEMS);
            if (nxt.may_idle && cmds_left > CALM_ITEMS && $urandom_range(0, 3) == 0)
              gap_left = $urandom_range(1, 12);
          end
        endcase
      end
      cmd_if.valid <= send;
    end
  end

  // Result side: long hold-off on request, otherwise random stall bursts
  always @(negedge clk) begin : rsp_ready_gen
    bit rdy;
    if (rst_n) begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_ok && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 11);
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_if.ready <= rdy;
    end
  end

  // Monitor: check results, predict on accepted commands, watch the clock
  always @(posedge clk) begin : monitor
    oqsud_pkg::result_t want;
    cycles++;
    cmd_fire = (rst_n === 1'b1) && (cmd_if.valid === 1'b1) && (cmd_if.ready === 1'b1);
    rsp_fire = (rst_n === 1'b1) && (rsp_if.valid === 1'b1) && (rsp_if.ready === 1'b1);
    if (rsp_fire) begin
      results_seen++;
      status_seen[rsp_if.status]++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %h value %h last %b",
                 $time, rsp_if.status, rsp_if.entry_value, rsp_if.last_item);
      end else begin
        want = due_results.pop_front();
        report_field("status", want.status, rsp_if.status);
        report_field("entry_value", want.entry_value, rsp_if.entry_value);
        report_field("last_item", want.last_item, rsp_if.last_item);
      end
    end
    if (cmd_fire) begin
      cmds_taken++;
      op_seen[cmd_if.opcode]++;
      if (cmd_if.opcode >= OP_RSVD_FIRST) ignored_cmds++;
      apply_command(cmd_if.opcode, cmd_if.key_value, cmd_if.new_value);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due",
               $time, cycles, due_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Build the stimulus, reset, then wait for the run to finish
  initial begin : stimulus
    bit                         grow;
    int                         pick;
    logic [oqsud_pkg::OP_W-1:0] op;

    cmd_if.valid     = 1'b0;
    cmd_if.opcode    = oqsud_pkg::OP_APPEND;
    cmd_if.key_value = '0;
    cmd_if.new_value = '0;
    rsp_if.ready     = 1'b0;
    rst_n            = 1'b0;

    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = KEY_NEG;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom();

    // Directed: empty queue, extremes, first-match rules, head/middle/tail delete
    queue_cmd(oqsud_pkg::OP_DUMP,   32'd0,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_SEARCH, KEY_MIN,   32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_MODIFY, KEY_MAX,   32'd1,   1'b0);
    queue_cmd(oqsud_pkg::OP_DELETE, 32'd0,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, KEY_MIN,   32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, KEY_MAX,   32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, KEY_NEG,   32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, 32'd5,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, 32'd0,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, 32'd5,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_SEARCH, 32'd5,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_SEARCH, 32'd1234,  32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_MODIFY, 32'd5,     32'd77,  1'b0);
    queue_cmd(oqsud_pkg::OP_MODIFY, 32'd999,   KEY_NEG, 1'b0);
    queue_cmd(oqsud_pkg::OP_DELETE, KEY_NEG,   32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_DELETE, 32'd5,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_DELETE, KEY_MIN,   32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_APPEND, 32'd42,    32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_DELETE, 32'd31337, 32'd0,   1'b0);
    queue_cmd(OP_RSVD_LAST,         KEY_NEG,   KEY_NEG, 1'b0);
    queue_cmd(oqsud_pkg::OP_DUMP,   32'd0,     32'd0,   1'b0);
    queue_cmd(oqsud_pkg::OP_MODIFY, KEY_MAX,   KEY_MIN, 1'b0);
    queue_cmd(oqsud_pkg::OP_DUMP,   32'd0,     32'd0,   1'b0);
    queue_marker(K_DRAIN);

    // Fill to full, overflow twice, then a full-length dump
    for (int i = 0; i < 14; i++) begin
      queue_cmd(oqsud_pkg::OP_APPEND, pick_key(50), $urandom(), 1'b1);
    end
    queue_cmd(oqsud_pkg::OP_DUMP, $urandom(), $urandom(), 1'b1);

    // Random mix, alternating segments that grow and shrink the queue
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 30) queue_marker(K_HOLD);
      if (n == 55) queue_marker(K_DRAIN);
      grow = ((n / 20) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3)
        op = oqsud_pkg::OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      else if (pick < 15)                op = oqsud_pkg::OP_DUMP;
      else if (pick < 30)                op = oqsud_pkg::OP_SEARCH;
      else if (pick < 45)                op = oqsud_pkg::OP_MODIFY;
      else if (pick < (grow ? 60 : 90))  op = oqsud_pkg::OP_DELETE;
      else                               op = oqsud_pkg::OP_APPEND;
      queue_cmd(op, pick_key((op == oqsud_pkg::OP_APPEND) ? 70 : 80), pick_key(50), 1'b1);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmds_taken < cmds_total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, due_results.size());
    end

    $display("Ran %0d commands: %0d append, %0d search, %0d modify, %0d delete, %0d dump, %0d ignored",
             cmds_taken, op_seen[oqsud_pkg::OP_APPEND], op_seen[oqsud_pkg::OP_SEARCH],
             op_seen[oqsud_pkg::OP_MODIFY], op_seen[oqsud_pkg::OP_DELETE],
             op_seen[oqsud_pkg::OP_DUMP], ignored_cmds);
    $display("Checked %0d results: %0d done, %0d not found, %0d empty queue, %0d full queue",
             results_seen, status_seen[oqsud_pkg::ST_DONE], status_seen[oqsud_pkg::ST_NOT_FOUND],
             status_seen[oqsud_pkg::ST_EMPTY], status_seen[oqsud_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
